### rtl/core/asc_pkg.sv
// Package for the approach, stop and turn controller.
// Holds the phase encoding, register indexes, reset values and payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

  typedef enum logic [1:0] {
    PH_FORWARD = 2'd0,
    PH_ROTATE  = 2'd1,
    PH_AWAIT   = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_STOP_DIST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TURN_AMT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ATTACH     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FWD_SPEED  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TURN_RATE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_TOL  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PROP_BAND  = 3'd6;

  typedef struct packed {
    logic [15:0]        stop_distance;
    logic signed [15:0] turn_amount;
    logic               attach_flag;
    logic [11:0]        forward_speed;
    logic [13:0]        turn_rate;
    logic [11:0]        angle_tolerance;
    logic [12:0]        proportional_band;
  } cfg_t;

  // 0.3 m, -90 deg, off, 0.5 m/s, 0.8 rad/s, 0.02 rad, 0.3 rad
  localparam cfg_t CFG_RESET = '{
    stop_distance:     16'd300,
    turn_amount:       -16'sd16384,
    attach_flag:       1'b0,
    forward_speed:     12'd500,
    turn_rate:         14'd8344,
    angle_tolerance:   12'd209,
    proportional_band: 13'd3129
  };

  typedef struct packed {
    logic [15:0]        front_distance;
    logic signed [15:0] heading;
    logic               service_done;
  } in_req_t;

  typedef struct packed {
    logic               publish;
    logic [11:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               service_request;
    logic               request_attach;
    logic [1:0]         phase_out;
    logic               finished;
  } out_res_t;

endpackage

`default_nettype wire

### rtl/core/asc_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for both the tick request and the result channel; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface asc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/asc_step.sv
// Per-tick control law: phase transition, target latch and command outputs.
// Purely combinational; depends on asc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asc_step (
  input  asc_pkg::cfg_t     cfg_i,
  input  asc_pkg::phase_e   phase_i,
  input  logic [15:0]       target_i,
  input  asc_pkg::in_req_t  req_i,
  output asc_pkg::phase_e   phase_o,
  output logic [15:0]       target_o,
  output asc_pkg::out_res_t res_o
);
  import asc_pkg::*;

  logic signed [15:0] err;
  logic [16:0]        err_x;
  logic [16:0]        mag;
  logic               in_tol;
  logic               in_band;

  // heading error wraps modulo a full turn
  assign err     = $signed(target_i - req_i.heading);
  assign err_x   = {err[15], err};
  assign mag     = err[15] ? (17'd0 - err_x) : err_x;
  assign in_tol  = mag < {5'd0, cfg_i.angle_tolerance};
  assign in_band = mag < {4'd0, cfg_i.proportional_band};

  always_comb begin
    phase_o = phase_i;
    target_o = target_i;
    res_o = '0;
    case (phase_i)
      PH_FORWARD: begin
        res_o.publish = 1'b1;
        if (req_i.front_distance <= cfg_i.stop_distance) begin
          target_o = req_i.heading + cfg_i.turn_amount;
          phase_o = PH_ROTATE;
        end else begin
          res_o.linear_cmd = cfg_i.forward_speed;
        end
      end
      PH_ROTATE: begin
        res_o.publish = 1'b1;
        if (in_tol) begin
          phase_o = PH_AWAIT;
          res_o.service_request = 1'b1;
          res_o.request_attach = cfg_i.attach_flag;
        end else if (in_band) begin
          // |err| < 8191 here, so doubling fits in 16 bits
          res_o.angular_cmd = {err[14:0], 1'b0};
        end else if (!err[15] && err != 16'sd0) begin
          res_o.angular_cmd = $signed({2'b00, cfg_i.turn_rate});
        end else begin
          res_o.angular_cmd = $signed(16'd0 - {2'b00, cfg_i.turn_rate});
        end
      end
      PH_AWAIT: begin
        if (req_i.service_done) begin
          phase_o = PH_DONE;
        end
      end
      default: begin
        phase_o = PH_DONE;
      end
    endcase
    res_o.phase_out = phase_o;
    res_o.finished = (phase_o == PH_DONE);
  end

endmodule

`default_nettype wire

### rtl/core/approach_stop_and_turn_controller.sv
// Approach, stop and turn controller: one result per control tick request.
// A request is registered, evaluated against the phase and target registers,
// and the result waits in an output register until taken. A new request is
// accepted every cycle while the result path flows; an accepted request passes
// the input register and then the output register. Throughput is set by the
// single evaluation stage, which updates phase and target each tick. The user
// must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// The block does not enforce this. Depends on asc_pkg, asc_stream_if and asc_step.
`timescale 1ns / 1ps
`default_nettype none

module approach_stop_and_turn_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [asc_pkg::CfgDataW-1:0]  cfg_data_i,
  asc_stream_if.sink                    req_i,
  asc_stream_if.source                  res_o
);
  import asc_pkg::*;

  cfg_t     cfg_q;
  phase_e   phase_q, phase_d;
  logic [15:0] tgt_q, tgt_d;
  logic     in_vld_q;
  in_req_t  in_q;
  logic     out_vld_q;
  out_res_t out_q, res_d;
  logic     eval_fire;
  logic     in_fire;

  assign eval_fire   = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || eval_fire;
  assign in_fire     = req_i.valid && req_i.ready;
  assign res_o.valid = out_vld_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STOP_DIST: cfg_q.stop_distance     <= cfg_data_i;
        CFG_TURN_AMT:  cfg_q.turn_amount       <= $signed(cfg_data_i);
        CFG_ATTACH:    cfg_q.attach_flag       <= cfg_data_i[0];
        CFG_FWD_SPEED: cfg_q.forward_speed     <= cfg_data_i[11:0];
        CFG_TURN_RATE: cfg_q.turn_rate         <= cfg_data_i[13:0];
        CFG_ANGLE_TOL: cfg_q.angle_tolerance   <= cfg_data_i[11:0];
        CFG_PROP_BAND: cfg_q.proportional_band <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  asc_step u_step (
    .cfg_i    (cfg_q),
    .phase_i  (phase_q),
    .target_i (tgt_q),
    .req_i    (in_q),
    .phase_o  (phase_d),
    .target_o (tgt_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FORWARD;
      tgt_q     <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (eval_fire) begin
        in_vld_q <= 1'b0;
      end
      if (eval_fire) begin
        phase_q   <= phase_d;
        tgt_q     <= tgt_d;
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= req_i.payload;
    end
    if (eval_fire) begin
      out_q <= res_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("completed phase left without reset");

  a_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FORWARD |=> (phase_q == PH_FORWARD || phase_q == PH_ROTATE))
    else $error("forward phase skipped rotation");

  a_req_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.service_request) |->
      (out_q.phase_out == PH_AWAIT && out_q.publish))
    else $error("service request outside rotation completion");

  a_tgt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_FORWARD && !$rose(phase_q == PH_ROTATE)) |=> $stable(tgt_q))
    else $error("target heading changed after latch");

endmodule

`default_nettype wire

### tb/sv/tb_approach_stop_and_turn_controller.sv
// Self-checking testbench for approach_stop_and_turn_controller.
// Drives control ticks through the request stream, predicts each result and
// checks it field by field; depends on asc_pkg, asc_stream_if and the RTL.
`timescale 1ns / 1ps

module tb_approach_stop_and_turn_controller;
  import asc_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  asc_stream_if #(.payload_t(in_req_t))  req_if ();
  asc_stream_if #(.payload_t(out_res_t)) res_if ();

  approach_stop_and_turn_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // controller model state
  cfg_t        ctl_regs;
  phase_e      cur_phase;
  logic [15:0] aim_heading;

  in_req_t  tick_q[$];
  out_res_t result_q[$];
  int ticks_queued;
  int ticks_taken;
  int error_cnt;
  int send_idle_pct;
  int recv_idle_pct;
  int send_gap;
  int recv_gap;
  int stall_left;
  bit hold_off_req;
  int unsigned cycle_cnt = 0;
  out_res_t seen_res;
  out_res_t due_res;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic out_res_t step_controller(in_req_t t);
    out_res_t r;
    logic [15:0] err_raw;
    int err;
    int mag;
    int rate;
    r = '0;
    case (cur_phase)
      PH_FORWARD: begin
        r.publish = 1'b1;
        if (t.front_distance <= ctl_regs.stop_distance) begin
          aim_heading = t.heading + ctl_regs.turn_amount;
          cur_phase = PH_ROTATE;
        end else begin
          r.linear_cmd = ctl_regs.forward_speed;
        end
      end
      PH_ROTATE: begin
        err_raw = aim_heading - t.heading;
        err = $signed(err_raw);
        mag = (err < 0) ? -err : err;
        rate = ctl_regs.turn_rate;
        r.publish = 1'b1;
        if (mag < int'(ctl_regs.angle_tolerance)) begin
          cur_phase = PH_AWAIT;
          r.service_request = 1'b1;
          r.request_attach = ctl_regs.attach_flag;
        end else if (mag < int'(ctl_regs.proportional_band)) begin
          r.angular_cmd = 16'(2 * err);
        end else begin
          r.angular_cmd = (err > 0) ? 16'(rate) : 16'(-rate);
        end
      end
      PH_AWAIT: begin
        if (t.service_done) cur_phase = PH_DONE;
      end
      default: cur_phase = PH_DONE;
    endcase
    r.phase_out = cur_phase;
    r.finished = (cur_phase == PH_DONE);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      send_gap <= 0;
    end else if (req_if.valid && !req_if.ready) begin
    end else if (send_gap != 0) begin
      req_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (tick_q.size() != 0) begin
      if ($urandom_range(1, 100) <= send_idle_pct) begin
        req_if.valid <= 1'b0;
        send_gap <= $urandom_range(0, 13);
      end else begin
        req_if.valid <= 1'b1;
        req_if.payload <= tick_q.pop_front();
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap <= 0;
      stall_left <= 0;
    end else if (hold_off_req) begin
      hold_off_req <= 1'b0;
      stall_left <= 400;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= recv_idle_pct) begin
      recv_gap <= $urandom_range(0, 13);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // predict on each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      result_q.push_back(step_controller(req_if.payload));
      ticks_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_res = res_if.payload;
      if (result_q.size() == 0) begin
        $error("result with no pending request");
        error_cnt++;
      end else begin
        due_res = result_q.pop_front();
        check_field("publish", due_res.publish, seen_res.publish);
        check_field("linear_cmd", due_res.linear_cmd, seen_res.linear_cmd);
        check_field("angular_cmd", due_res.angular_cmd, seen_res.angular_cmd);
        check_field("service_request", due_res.service_request,
                    seen_res.service_request);
        check_field("request_attach", due_res.request_attach,
                    seen_res.request_attach);
        check_field("phase_out", due_res.phase_out, seen_res.phase_out);
        check_field("finished", due_res.finished, seen_res.finished);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_approach_stop_and_turn_controller: FAIL");
      $finish;
    end
  end

  task automatic queue_tick(int front_mm, int head, int done);
    in_req_t t;
    t.front_distance = 16'(front_mm);
    t.heading = 16'(head);
    t.service_done = done[0];
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic queue_noise(int done);
    queue_tick($urandom_range(0, 65535), $urandom_range(0, 65535), done);
  endtask

  // heading that gives the wanted error against the latched target
  task automatic queue_err(int err);
    queue_tick($urandom_range(0, 65535), int'(aim_heading) - err,
               $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (ticks_taken != ticks_queued || result_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(data);
    case (idx)
      CFG_STOP_DIST: ctl_regs.stop_distance = 16'(data);
      CFG_TURN_AMT:  ctl_regs.turn_amount = 16'(data);
      CFG_ATTACH:    ctl_regs.attach_flag = data[0];
      CFG_FWD_SPEED: ctl_regs.forward_speed = data[11:0];
      CFG_TURN_RATE: ctl_regs.turn_rate = data[13:0];
      CFG_ANGLE_TOL: ctl_regs.angle_tolerance = data[11:0];
      CFG_PROP_BAND: ctl_regs.proportional_band = data[12:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_idling();
    send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
    recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
  endtask

  initial begin
    int s;
    int m;
    int e;
    int tol;
    int band;
    int k;
    int n;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    ctl_regs = CFG_RESET;
    cur_phase = PH_FORWARD;
    aim_heading = '0;
    ticks_queued = 0;
    ticks_taken = 0;
    error_cnt = 0;
    hold_off_req = 1'b0;
    pick_idling();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // forward with reset settings; early service_done is ignored
    queue_tick(65535, 16'h7FFF, 1'b1);
    queue_tick(301, 16'h8000, 1'b0);
    queue_tick(65534, 0, 1'b1);
    queue_tick(301, 16'hFFFF, 1'b1);
    wait_idle();

    pick_idling();
    write_reg(CFG_STOP_DIST, 16'h0000);
    write_reg(CFG_FWD_SPEED, 16'hFFFF);
    end_writes();
    queue_tick(1, 0, 1'b1);
    for (k = 0; k < 120; k++) queue_tick($urandom_range(1, 65535),
                                         $urandom_range(0, 65535), $urandom_range(0, 1));
    wait_idle();

    pick_idling();
    write_reg(CFG_STOP_DIST, 16'hFFFE);
    write_reg(CFG_FWD_SPEED, 16'hF000);
    end_writes();
    for (k = 0; k < 20; k++) queue_tick(65535, $urandom_range(0, 65535), 1'b1);
    wait_idle();

    pick_idling();
    s = $urandom_range(0, 60000);
    write_reg(CFG_STOP_DIST, s);
    write_reg(CFG_FWD_SPEED, $urandom_range(0, 65535));
    end_writes();
    for (k = 0; k < 150; k++) queue_tick($urandom_range(s + 1, 65535),
                                         $urandom_range(0, 65535), $urandom_range(0, 1));
    wait_idle();

    // stop tick latches the target
    case ($urandom_range(0, 2))
      0: write_reg(CFG_TURN_AMT, 16'h8000);
      1: write_reg(CFG_TURN_AMT, 16'h7FFF);
      default: write_reg(CFG_TURN_AMT, $urandom_range(0, 65535));
    endcase
    s = $urandom_range(0, 65535);
    write_reg(CFG_STOP_DIST, s);
    write_reg(CFG_ANGLE_TOL, {4'($urandom_range(0, 15)), 12'h000});
    write_reg(CFG_PROP_BAND, 16'hFFFF);
    end_writes();
    queue_tick($urandom_range(0, 1) ? s : $urandom_range(0, s),
               $urandom_range(0, 65535), $urandom_range(0, 1));
    wait_idle();

    // band edges, half-turn error, zero error
    queue_err(0);
    queue_err(-32768);
    queue_err(8190);
    queue_err(-8190);
    queue_err(8191);
    queue_err(-8191);
    wait_idle();
    write_reg(CFG_PROP_BAND, 16'h0000);
    end_writes();
    queue_err(0);
    queue_err(1);
    wait_idle();

    // rotation never completes while the tolerance is zero
    for (k = 0; k < 7; k++) begin
      pick_idling();
      case (k)
        0: write_reg(CFG_TURN_RATE, 16'h0000);
        1: write_reg(CFG_TURN_RATE, 16'hFFFF);
        default: write_reg(CFG_TURN_RATE, $urandom_range(0, 65535));
      endcase
      case (k)
        0: write_reg(CFG_PROP_BAND, 16'hFFFF);
        1: write_reg(CFG_PROP_BAND, 16'h0000);
        2: write_reg(CFG_PROP_BAND, 16'hE000);
        default: write_reg(CFG_PROP_BAND, $urandom_range(0, 65535));
      endcase
      write_reg(CFG_ANGLE_TOL, {4'($urandom_range(0, 15)), 12'h000});
      end_writes();
      band = ctl_regs.proportional_band;
      for (n = 0; n < 150; n++) begin
        if ($urandom_range(0, 1)) begin
          queue_noise($urandom_range(0, 1));
        end else begin
          m = $urandom_range(0, band + 2);
          queue_err($urandom_range(0, 1) ? -m : m);
        end
      end
      if (k == 0) hold_off_req = 1'b1;
      wait_idle();
    end

    // nonzero tolerance, errors kept at or beyond it
    pick_idling();
    tol = $urandom_range(1, 4095);
    write_reg(CFG_ANGLE_TOL, {4'($urandom_range(0, 15)), 12'(tol)});
    write_reg(CFG_PROP_BAND, $urandom_range(0, 65535));
    end_writes();
    queue_err(tol);
    queue_err(-tol);
    for (n = 0; n < 100; n++) begin
      m = $urandom_range(tol, 32768);
      e = $urandom_range(0, 1) ? -m : m;
      queue_err((e == 32768) ? -32768 : e);
    end
    wait_idle();

    // rotation completes and the service request goes out with attach set
    pick_idling();
    tol = $urandom_range(1, 4095);
    write_reg(CFG_ATTACH, {15'($urandom_range(0, 32767)), 1'b1});
    write_reg(CFG_ANGLE_TOL, tol);
    end_writes();
    for (n = 0; n < 5; n++) begin
      m = $urandom_range(tol, 32767);
      queue_err($urandom_range(0, 1) ? -m : m);
    end
    queue_err($urandom_range(0, 2 * tol - 2) - (tol - 1));
    wait_idle();

    // awaiting the service answer
    pick_idling();
    write_reg(CfgIdxUnused, $urandom_range(0, 65535));
    end_writes();
    for (n = 0; n < 40; n++) queue_noise(1'b0);
    queue_noise(1'b1);
    wait_idle();

    // completed is terminal; no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_STOP_DIST, 16'hFFFF);
    end_writes();
    for (n = 0; n < 200; n++) queue_noise($urandom_range(0, 1));
    wait_idle();
    repeat (10) @(negedge clk_i);

    if (error_cnt == 0) begin
      $display("tb_approach_stop_and_turn_controller: PASS");
    end else begin
      $display("tb_approach_stop_and_turn_controller: FAIL");
    end
    $finish;
  end

endmodule

### approach_stop_and_turn_controller.f
rtl/core/asc_pkg.sv
rtl/core/asc_stream_if.sv
rtl/core/asc_step.sv
rtl/core/approach_stop_and_turn_controller.sv
tb/sv/tb_approach_stop_and_turn_controller.sv
